/* hw/rtl/cpss_pkg.sv */
// Shared types, widths and arithmetic helpers for the segment closest-point block.
`default_nettype none
package cpss_pkg;

  localparam int COORD_W  = 16;             // Q8.8 coordinate code
  localparam int DIFF_W   = COORD_W + 1;    // endpoint difference
  localparam int DOT_W    = 2 * DIFF_W + 2; // sum of three products
  localparam int HALF_W   = DOT_W / 2;      // split point for wide products
  localparam int WIDE_W   = 2 * DOT_W;      // a*e - b*b and friends
  localparam int PF       = 16;             // fraction bits of s and t
  localparam int PAR_W    = PF + 1;
  localparam int TN_W     = DOT_W + PAR_W + 3;
  localparam int PROD_W   = DIFF_W + PAR_W + 2;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int DIST_W   = 2 * COORD_W + 4;
  localparam int TSTEPS   = PF + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [TN_W-1:0]    tnum_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic        [PAR_W-1:0]   par_t;
  typedef logic        [DIST_W-1:0]  dist_t;

  localparam par_t PAR_ONE = par_t'(2 ** PF);

  // partial products of a signed DOT_W x DOT_W multiply
  typedef struct packed {
    logic signed [DOT_W+1:0] hh;
    logic signed [DOT_W+1:0] hl;
    logic signed [DOT_W+1:0] lh;
    logic        [DOT_W-1:0] ll;
  } pp_t;

  // one restoring-division lane for a clamped ratio
  typedef struct packed {
    logic [WIDE_W-1:0] rem;
    logic [WIDE_W-1:0] den;
    logic [PF-1:0]     q;
    logic              one;
  } lane_t;

  // division lane for t
  typedef struct packed {
    logic [TN_W-1:0]  rem;
    logic [PAR_W-1:0] q;
  } tdiv_t;

  // geometry carried along the pipeline
  typedef struct packed {
    coord_t [2:0] p1;
    coord_t [2:0] p2;
    diff_t  [2:0] d1;
    diff_t  [2:0] d2;
    dot_t         b;
    dot_t         f;
    dot_t         e;
    logic         az;
    logic         ez;
  } ctx_t;

  // context through the t division
  typedef struct packed {
    ctx_t ctx;
    par_t sa;
    par_t sb;
    par_t sc;
    par_t sd;
    logic negc;
    logic hic;
  } tctx_t;

  function automatic pp_t pp_mul(dot_t x, dot_t y);
    pp_t o;
    logic signed [HALF_W-1:0] xh, yh;
    logic signed [HALF_W:0]   xl, yl;
    xh = x[DOT_W-1:HALF_W];
    yh = y[DOT_W-1:HALF_W];
    xl = {1'b0, x[HALF_W-1:0]};
    yl = {1'b0, y[HALF_W-1:0]};
    o.hh = xh * yh;
    o.hl = xh * yl;
    o.lh = xl * yh;
    o.ll = x[HALF_W-1:0] * y[HALF_W-1:0];
    return o;
  endfunction

  function automatic wide_t pp_sum(pp_t p);
    wide_t hh, mid, ll;
    hh  = wide_t'(p.hh) <<< (2 * HALF_W);
    mid = (wide_t'(p.hl) + wide_t'(p.lh)) <<< HALF_W;
    ll  = wide_t'(p.ll);
    return hh + mid + ll;
  endfunction

  // zero, one or the start of a long division, for clamp(num/den, 0, 1)
  function automatic lane_t lane_init(wide_t num, wide_t den);
    lane_t o;
    logic  vn;
    vn    = (num > 0) && (den != '0);
    o.one = vn && (num >= den);
    o.den = $unsigned(den);
    o.rem = (vn && !o.one) ? $unsigned(num) : '0;
    o.q   = '0;
    return o;
  endfunction

  function automatic lane_t lane_step(lane_t l);
    lane_t             o;
    logic [WIDE_W-1:0] r2;
    o   = l;
    r2  = {l.rem[WIDE_W-2:0], 1'b0};
    o.q = {l.q[PF-2:0], 1'b0};
    if (r2 >= l.den && r2 != '0) begin
      o.rem  = r2 - l.den;
      o.q[0] = 1'b1;
    end else begin
      o.rem = r2;
    end
    return o;
  endfunction

  function automatic par_t lane_res(lane_t l);
    return l.one ? PAR_ONE : {1'b0, l.q};
  endfunction

  // one quotient bit of t, divisor e shifted by sh
  function automatic tdiv_t t_step(tdiv_t x, dot_t e, int sh);
    tdiv_t           o;
    logic [TN_W-1:0] dv;
    dv = TN_W'($unsigned(e)) << sh;
    if (x.rem >= dv) begin
      o.rem = x.rem - dv;
      o.q   = {x.q[PAR_W-2:0], 1'b1};
    end else begin
      o.rem = x.rem;
      o.q   = {x.q[PAR_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cpss_if.sv */
// Valid/ready channel interfaces for segment pairs and closest-point results.
`default_nettype none
interface cpss_in_if;
  import cpss_pkg::*;
  logic   valid;
  logic   ready;
  coord_t seg1_start_x, seg1_start_y, seg1_start_z;
  coord_t seg1_end_x, seg1_end_y, seg1_end_z;
  coord_t seg2_start_x, seg2_start_y, seg2_start_z;
  coord_t seg2_end_x, seg2_end_y, seg2_end_z;
  modport source (output valid, output seg1_start_x, seg1_start_y, seg1_start_z,
                  output seg1_end_x, seg1_end_y, seg1_end_z,
                  output seg2_start_x, seg2_start_y, seg2_start_z,
                  output seg2_end_x, seg2_end_y, seg2_end_z, input ready);
  modport sink (input valid, input seg1_start_x, seg1_start_y, seg1_start_z,
                input seg1_end_x, seg1_end_y, seg1_end_z,
                input seg2_start_x, seg2_start_y, seg2_start_z,
                input seg2_end_x, seg2_end_y, seg2_end_z, output ready);
endinterface

interface cpss_out_if;
  import cpss_pkg::*;
  logic   valid;
  logic   ready;
  par_t   param_s, param_t;
  coord_t near1_x, near1_y, near1_z;
  coord_t near2_x, near2_y, near2_z;
  dist_t  dist_squared;
  modport source (output valid, output param_s, param_t, near1_x, near1_y, near1_z,
                  output near2_x, near2_y, near2_z, dist_squared, input ready);
  modport sink (input valid, input param_s, param_t, near1_x, near1_y, near1_z,
                input near2_x, near2_y, near2_z, dist_squared, output ready);
endinterface
`default_nettype wire

/* hw/rtl/closest_points_between_segments.sv */
// Closest points between two 3-D segments: 45-stage pipeline, one item per cycle.
//
// in_item carries the four Q8.8 endpoints of a segment pair; out_item returns
// s and t (Q1.16), both closest points rounded to Q8.8 and their squared
// distance in Q20.16. Both channels are valid/ready; an item moves when both
// are high.
// Throughput is one item per cycle while the output is not stalled. The
// depth comes from the 16-step division for s (four lanes in parallel)
// followed by the 17-step division for t, one quotient bit per stage, plus
// stages for the dot products, the split wide multiplies and the point
// placement.
// The whole pipeline advances together. When the result register holds an
// item the receiver has not taken, every stage holds and in_item.ready is low;
// nothing is lost or repeated. Empty stages still move while stalled output
// is empty.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline is empty
// and ready on the first cycle after reset.
`default_nettype none
module closest_points_between_segments (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cpss_in_if.sink    in_item,
  cpss_out_if.source out_item
);
  import cpss_pkg::*;

  localparam int NDIV = PF;

  logic en;

  // stage 1: differences
  logic          s1_vld_r;
  coord_t [2:0]  s1_p1_r, s1_p2_r;
  diff_t  [2:0]  s1_d1_r, s1_d2_r, s1_r_r;
  // stage 2: dot products
  logic          s2_vld_r;
  ctx_t          s2_ctx_r;
  dot_t          s2_a_r, s2_c_r;
  // stage 3: wide partial products
  logic          s3_vld_r;
  ctx_t          s3_ctx_r;
  dot_t          s3_a_r, s3_c_r;
  pp_t           s3_ae_r, s3_bb_r, s3_bf_r, s3_ce_r;
  // stage 4: denominator and numerator for s
  logic          s4_vld_r;
  ctx_t          s4_ctx_r;
  dot_t          s4_a_r, s4_c_r;
  wide_t         s4_den_r, s4_num_r;
  // division lanes for s
  logic          dv_vld_r [0:NDIV];
  ctx_t          dv_ctx_r [0:NDIV];
  lane_t         la_r [0:NDIV];
  lane_t         lb_r [0:NDIV];
  lane_t         lc_r [0:NDIV];
  lane_t         ld_r [0:NDIV];
  // stage after s: numerator of t
  logic          tn_vld_r;
  tctx_t         tn_ctx_r;
  tnum_t         tn_r;
  // t division
  logic          tv_vld_r [0:TSTEPS];
  tctx_t         tv_ctx_r [0:TSTEPS];
  tdiv_t         tv_r [0:TSTEPS];
  // final parameter selection
  logic          sel_vld_r;
  par_t          sel_s_r, sel_t_r, sel_s_nxt, sel_t_nxt;
  coord_t [2:0]  sel_p1_r, sel_p2_r;
  diff_t  [2:0]  sel_d1_r, sel_d2_r;
  // placement products
  logic          pm_vld_r;
  par_t          pm_s_r, pm_t_r;
  coord_t [2:0]  pm_p1_r, pm_p2_r;
  prod_t  [2:0]  pm_m1_r, pm_m2_r;
  // rounded points
  logic          np_vld_r;
  par_t          np_s_r, np_t_r;
  coord_t [2:0]  np_n1_r, np_n2_r;
  // squared differences
  logic          sq_vld_r;
  par_t          sq_s_r, sq_t_r;
  coord_t [2:0]  sq_n1_r, sq_n2_r;
  logic [SQ_W-1:0] sq_r [0:2];
  // result register
  logic          out_vld_r;
  par_t          out_s_r, out_t_r;
  coord_t [2:0]  out_n1_r, out_n2_r;
  dist_t         out_dist_r;

  assign en = !out_vld_r || out_item.ready;
  assign in_item.ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      tn_vld_r  <= 1'b0;
      sel_vld_r <= 1'b0;
      pm_vld_r  <= 1'b0;
      np_vld_r  <= 1'b0;
      sq_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int k = 0; k <= NDIV; k++) dv_vld_r[k] <= 1'b0;
      for (int k = 0; k <= TSTEPS; k++) tv_vld_r[k] <= 1'b0;
    end else if (en) begin
      s1_vld_r    <= in_item.valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      dv_vld_r[0] <= s4_vld_r;
      for (int k = 1; k <= NDIV; k++) dv_vld_r[k] <= dv_vld_r[k-1];
      tn_vld_r    <= dv_vld_r[NDIV];
      tv_vld_r[0] <= tn_vld_r;
      for (int k = 1; k <= TSTEPS; k++) tv_vld_r[k] <= tv_vld_r[k-1];
      sel_vld_r   <= tv_vld_r[TSTEPS];
      pm_vld_r    <= sel_vld_r;
      np_vld_r    <= pm_vld_r;
      sq_vld_r    <= np_vld_r;
      out_vld_r   <= sq_vld_r;
    end
  end

  // stage 1: endpoint differences
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p1_r <= {in_item.seg1_start_z, in_item.seg1_start_y, in_item.seg1_start_x};
      s1_p2_r <= {in_item.seg2_start_z, in_item.seg2_start_y, in_item.seg2_start_x};
      s1_d1_r[0] <= diff_t'(in_item.seg1_end_x) - diff_t'(in_item.seg1_start_x);
      s1_d1_r[1] <= diff_t'(in_item.seg1_end_y) - diff_t'(in_item.seg1_start_y);
      s1_d1_r[2] <= diff_t'(in_item.seg1_end_z) - diff_t'(in_item.seg1_start_z);
      s1_d2_r[0] <= diff_t'(in_item.seg2_end_x) - diff_t'(in_item.seg2_start_x);
      s1_d2_r[1] <= diff_t'(in_item.seg2_end_y) - diff_t'(in_item.seg2_start_y);
      s1_d2_r[2] <= diff_t'(in_item.seg2_end_z) - diff_t'(in_item.seg2_start_z);
      s1_r_r[0]  <= diff_t'(in_item.seg1_start_x) - diff_t'(in_item.seg2_start_x);
      s1_r_r[1]  <= diff_t'(in_item.seg1_start_y) - diff_t'(in_item.seg2_start_y);
      s1_r_r[2]  <= diff_t'(in_item.seg1_start_z) - diff_t'(in_item.seg2_start_z);
    end
  end

  // stage 2: the five dot products
  always_ff @(posedge clk) begin
    dot_t a, e, f, c, b;
    logic signed [SQ_W-1:0] m_a, m_e, m_f, m_c, m_b;
    a = '0; e = '0; f = '0; c = '0; b = '0;
    for (int i = 0; i < 3; i++) begin
      // full-width products of the 17-bit differences
      m_a = s1_d1_r[i] * s1_d1_r[i];
      m_e = s1_d2_r[i] * s1_d2_r[i];
      m_f = s1_d2_r[i] * s1_r_r[i];
      m_c = s1_d1_r[i] * s1_r_r[i];
      m_b = s1_d1_r[i] * s1_d2_r[i];
      a = a + dot_t'(m_a);
      e = e + dot_t'(m_e);
      f = f + dot_t'(m_f);
      c = c + dot_t'(m_c);
      b = b + dot_t'(m_b);
    end
    if (en) begin
      s2_ctx_r.p1 <= s1_p1_r;
      s2_ctx_r.p2 <= s1_p2_r;
      s2_ctx_r.d1 <= s1_d1_r;
      s2_ctx_r.d2 <= s1_d2_r;
      s2_ctx_r.b  <= b;
      s2_ctx_r.f  <= f;
      s2_ctx_r.e  <= e;
      s2_ctx_r.az <= (a == '0);
      s2_ctx_r.ez <= (e == '0);
      s2_a_r      <= a;
      s2_c_r      <= c;
    end
  end

  // stages 3 and 4: wide products as partials, then summed
  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctx_r <= s2_ctx_r;
      s3_a_r   <= s2_a_r;
      s3_c_r   <= s2_c_r;
      s3_ae_r  <= pp_mul(s2_a_r, s2_ctx_r.e);
      s3_bb_r  <= pp_mul(s2_ctx_r.b, s2_ctx_r.b);
      s3_bf_r  <= pp_mul(s2_ctx_r.b, s2_ctx_r.f);
      s3_ce_r  <= pp_mul(s2_c_r, s2_ctx_r.e);
      s4_ctx_r <= s3_ctx_r;
      s4_a_r   <= s3_a_r;
      s4_c_r   <= s3_c_r;
      s4_den_r <= pp_sum(s3_ae_r) - pp_sum(s3_bb_r);
      s4_num_r <= pp_sum(s3_bf_r) - pp_sum(s3_ce_r);
    end
  end

  // lane set-up: general s, s with t at zero, s with t at one, t for a point
  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctx_r[0] <= s4_ctx_r;
      la_r[0] <= lane_init(s4_num_r, s4_den_r);
      lb_r[0] <= lane_init(-wide_t'(s4_c_r), wide_t'(s4_a_r));
      lc_r[0] <= lane_init(wide_t'(s4_ctx_r.b) - wide_t'(s4_c_r), wide_t'(s4_a_r));
      ld_r[0] <= lane_init(wide_t'(s4_ctx_r.f), wide_t'(s4_ctx_r.e));
    end
  end

  // one quotient bit per stage in each lane
  for (genvar k = 1; k <= NDIV; k++) begin : g_sdiv
    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctx_r[k] <= dv_ctx_r[k-1];
        la_r[k] <= lane_step(la_r[k-1]);
        lb_r[k] <= lane_step(lb_r[k-1]);
        lc_r[k] <= lane_step(lc_r[k-1]);
        ld_r[k] <= lane_step(ld_r[k-1]);
      end
    end
  end

  // numerator of t from the general s
  always_ff @(posedge clk) begin
    par_t sa;
    logic signed [DOT_W+PAR_W:0] bs;
    sa = lane_res(la_r[NDIV]);
    bs = dv_ctx_r[NDIV].b * $signed({1'b0, sa});
    if (en) begin
      tn_ctx_r.ctx  <= dv_ctx_r[NDIV];
      tn_ctx_r.sa   <= sa;
      tn_ctx_r.sb   <= lane_res(lb_r[NDIV]);
      tn_ctx_r.sc   <= lane_res(lc_r[NDIV]);
      tn_ctx_r.sd   <= lane_res(ld_r[NDIV]);
      tn_ctx_r.negc <= 1'b0;
      tn_ctx_r.hic  <= 1'b0;
      tn_r <= tnum_t'(bs) + (tnum_t'(dv_ctx_r[NDIV].f) <<< PF);
    end
  end

  // clamp tests for t and division set-up
  always_ff @(posedge clk) begin
    tnum_t e_t, lim;
    logic  negc, hic;
    tctx_t tc;
    e_t  = tnum_t'(tn_ctx_r.ctx.e);
    lim  = (e_t <<< PF) + e_t;
    negc = (tn_r < 0) && (-tn_r >= e_t);
    hic  = (tn_r >= lim);
    tc      = tn_ctx_r;
    tc.negc = negc;
    tc.hic  = hic;
    if (en) begin
      tv_ctx_r[0] <= tc;
      tv_r[0].rem <= (tn_r > 0 && !hic) ? $unsigned(tn_r) : '0;
      tv_r[0].q   <= '0;
    end
  end

  for (genvar k = 1; k <= TSTEPS; k++) begin : g_tdiv
    always_ff @(posedge clk) begin
      if (en) begin
        tv_ctx_r[k] <= tv_ctx_r[k-1];
        tv_r[k]     <= t_step(tv_r[k-1], tv_ctx_r[k-1].ctx.e, TSTEPS - k);
      end
    end
  end

  // pick s and t by segment case and clamp
  always_comb begin
    tctx_t x;
    x = tv_ctx_r[TSTEPS];
    if (x.ctx.az && x.ctx.ez) begin
      sel_s_nxt = '0;
      sel_t_nxt = '0;
    end else if (x.ctx.az) begin
      sel_s_nxt = '0;
      sel_t_nxt = x.sd;
    end else if (x.ctx.ez) begin
      sel_s_nxt = x.sb;
      sel_t_nxt = '0;
    end else if (x.negc) begin
      sel_s_nxt = x.sb;
      sel_t_nxt = '0;
    end else if (x.hic) begin
      sel_s_nxt = x.sc;
      sel_t_nxt = PAR_ONE;
    end else begin
      sel_s_nxt = x.sa;
      sel_t_nxt = tv_r[TSTEPS].q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_s_r  <= sel_s_nxt;
      sel_t_r  <= sel_t_nxt;
      sel_p1_r <= tv_ctx_r[TSTEPS].ctx.p1;
      sel_p2_r <= tv_ctx_r[TSTEPS].ctx.p2;
      sel_d1_r <= tv_ctx_r[TSTEPS].ctx.d1;
      sel_d2_r <= tv_ctx_r[TSTEPS].ctx.d2;
    end
  end

  // placement (d times parameter, round half up, add start point), squared diffs
  always_ff @(posedge clk) begin
    prod_t  q1, q2;
    diff_t  df;
    if (en) begin
      pm_s_r  <= sel_s_r;
      pm_t_r  <= sel_t_r;
      pm_p1_r <= sel_p1_r;
      pm_p2_r <= sel_p2_r;
      for (int i = 0; i < 3; i++) begin
        pm_m1_r[i] <= $signed(sel_d1_r[i]) * $signed({1'b0, sel_s_r});
        pm_m2_r[i] <= $signed(sel_d2_r[i]) * $signed({1'b0, sel_t_r});
      end
      np_s_r <= pm_s_r;
      np_t_r <= pm_t_r;
      for (int i = 0; i < 3; i++) begin
        q1 = (pm_m1_r[i] + prod_t'(2 ** (PF - 1))) >>> PF;
        q2 = (pm_m2_r[i] + prod_t'(2 ** (PF - 1))) >>> PF;
        np_n1_r[i] <= COORD_W'(prod_t'(pm_p1_r[i]) + q1);
        np_n2_r[i] <= COORD_W'(prod_t'(pm_p2_r[i]) + q2);
      end
      sq_s_r  <= np_s_r;
      sq_t_r  <= np_t_r;
      sq_n1_r <= np_n1_r;
      sq_n2_r <= np_n2_r;
      for (int i = 0; i < 3; i++) begin
        df = diff_t'(np_n1_r[i]) - diff_t'(np_n2_r[i]);
        sq_r[i] <= df * df;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      out_s_r    <= sq_s_r;
      out_t_r    <= sq_t_r;
      out_n1_r   <= sq_n1_r;
      out_n2_r   <= sq_n2_r;
      out_dist_r <= dist_t'(sq_r[0]) + dist_t'(sq_r[1]) + dist_t'(sq_r[2]);
    end
  end

  assign out_item.valid        = out_vld_r;
  assign out_item.param_s      = out_s_r;
  assign out_item.param_t      = out_t_r;
  assign out_item.near1_x      = out_n1_r[0];
  assign out_item.near1_y      = out_n1_r[1];
  assign out_item.near1_z      = out_n1_r[2];
  assign out_item.near2_x      = out_n2_r[0];
  assign out_item.near2_y      = out_n2_r[1];
  assign out_item.near2_z      = out_n2_r[2];
  assign out_item.dist_squared = out_dist_r;

endmodule
`default_nettype wire

/* bench/tb_closest_points_between_segments.sv */
// Self-checking bench for the segment closest-point pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_closest_points_between_segments;
  import cpss_pkg::*;

  typedef logic signed [127:0] acc_t;

  typedef struct {
    coord_t c [12];  // P1 xyz, Q1 xyz, P2 xyz, Q2 xyz
  } pair_t;

  typedef struct {
    par_t   s, t;
    coord_t n1 [3];
    coord_t n2 [3];
    dist_t  dsq;
  } near_t;

  typedef struct {
    pair_t pair;
    bit    typed;  // expected result given in the row
    near_t res;
  } row_t;

  localparam longint ONE = 64'sd1 << PF;
  localparam int LIMIT = 400000;

  logic clk;
  logic rst_n;
  cpss_in_if  in_item ();
  cpss_out_if out_item ();

  closest_points_between_segments uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item)
  );

  near_t  near_q [$];
  int     errors;
  int     n_sent;
  int     n_got;
  int     idle_pct;
  int     stall_pct;
  int     cycles;
  row_t   rows [$];

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_par(longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  // point on a segment, rounded half up to the coordinate grid
  function automatic longint place_pt(longint p, longint d, longint par);
    longint x;
    x = d * par + ONE / 2;
    return p + (x >>> PF);
  endfunction

  // closest points between the two segments of a pair
  function automatic near_t closest(pair_t pr);
    near_t  o;
    longint p1 [3], p2 [3], d1 [3], d2 [3], r [3];
    longint a, e, f, c, b, s, t, n1, n2, df;
    acc_t   den, num;
    a = 0; e = 0; f = 0; c = 0; b = 0; s = 0; t = 0;
    for (int i = 0; i < 3; i++) begin
      p1[i] = pr.c[i];
      p2[i] = pr.c[6 + i];
      d1[i] = longint'(pr.c[3 + i]) - p1[i];
      d2[i] = longint'(pr.c[9 + i]) - p2[i];
      r[i]  = p1[i] - p2[i];
      a += d1[i] * d1[i];
      e += d2[i] * d2[i];
      f += d2[i] * r[i];
      c += d1[i] * r[i];
      b += d1[i] * d2[i];
    end
    if (a == 0 && e == 0) begin
      s = 0;
      t = 0;
    end else if (a == 0) begin
      t = clamp_par(f * ONE / e);
    end else if (e == 0) begin
      s = clamp_par(-c * ONE / a);
    end else begin
      den = acc_t'(a) * acc_t'(e) - acc_t'(b) * acc_t'(b);
      num = acc_t'(b) * acc_t'(f) - acc_t'(c) * acc_t'(e);
      if (den == 0 || num <= 0) s = 0;
      else if (num >= den) s = ONE;
      else s = longint'((num * acc_t'(ONE)) / den);
      t = (b * s + f * ONE) / e;
      if (t < 0) begin
        t = 0;
        s = clamp_par(-c * ONE / a);
      end else if (t > ONE) begin
        t = ONE;
        s = clamp_par((b - c) * ONE / a);
      end
    end
    o.s = par_t'(s);
    o.t = par_t'(t);
    o.dsq = '0;
    for (int i = 0; i < 3; i++) begin
      n1 = place_pt(p1[i], d1[i], s);
      n2 = place_pt(p2[i], d2[i], t);
      df = n1 - n2;
      o.n1[i] = coord_t'(n1);
      o.n2[i] = coord_t'(n2);
      o.dsq = o.dsq + dist_t'(df * df);
    end
    return o;
  endfunction

  function automatic pair_t mk(int v [12]);
    pair_t p;
    for (int i = 0; i < 12; i++) p.c[i] = coord_t'(v[i]);
    return p;
  endfunction

  function automatic near_t mk_res(int s, int t, int n1 [3], int n2 [3], longint dsq);
    near_t o;
    o.s = par_t'(s);
    o.t = par_t'(t);
    for (int i = 0; i < 3; i++) begin
      o.n1[i] = coord_t'(n1[i]);
      o.n2[i] = coord_t'(n2[i]);
    end
    o.dsq = dist_t'(dsq);
    return o;
  endfunction

  function automatic void add_row(int v [12]);
    row_t r;
    r.pair  = mk(v);
    r.typed = 1'b0;
    rows.push_back(r);
  endfunction

  function automatic void add_typed(int v [12], near_t res);
    row_t r;
    r.pair  = mk(v);
    r.typed = 1'b1;
    r.res   = res;
    rows.push_back(r);
  endfunction

  // directed rows
  function automatic void build_rows();
    // all at the origin
    add_typed('{0,0,0, 0,0,0, 0,0,0, 0,0,0},
              mk_res(0, 0, '{0,0,0}, '{0,0,0}, 0));
    // both segments are points
    add_typed('{256,0,0, 256,0,0, 0,0,0, 0,0,0},
              mk_res(0, 0, '{256,0,0}, '{0,0,0}, 65536));
    // both points at opposite extremes on x
    add_typed('{32767,0,0, 32767,0,0, -32768,0,0, -32768,0,0},
              mk_res(0, 0, '{32767,0,0}, '{-32768,0,0}, 64'd4294836225));
    // every field at the extremes, then a row of -1s and zeros
    add_row('{-32768,-32768,-32768, 32767,32767,32767,
              32767,32767,32767, -32768,-32768,-32768});
    add_row('{32767,-32768,32767, -32768,32767,-32768,
              -32768,32767,-32768, 32767,-32768,32767});
    add_row('{-32768,-32768,-32768, -32768,-32768,-32768,
              32767,32767,32767, -32768,32767,-32768});
    add_row('{-1,-1,-1, -1,-1,-1, -1,-1,-1, 0,0,0});
    // first segment is a point, t inside, below and above range
    add_row('{0,256,0, 0,256,0, -512,0,0, 512,0,0});
    add_row('{-1024,0,0, -1024,0,0, 0,0,0, 512,0,0});
    add_row('{1024,0,0, 1024,0,0, 0,0,0, 512,0,0});
    // second segment is a point
    add_row('{-512,0,0, 512,0,0, 0,256,0, 0,256,0});
    add_row('{-512,0,0, 512,0,0, -2048,256,0, -2048,256,0});
    add_row('{-512,0,0, 512,0,0, 2048,256,0, 2048,256,0});
    // crossing segments
    add_row('{-512,0,0, 512,0,0, 0,-512,256, 0,512,256});
    add_row('{-300,17,5, 700,-20,90, 40,-600,300, 10,500,-200});
    // parallel and collinear
    add_row('{0,0,0, 1024,0,0, 0,256,0, 1024,256,0});
    add_row('{0,0,0, 1024,0,0, 2048,0,0, 3072,0,0});
    add_row('{0,0,0, 1024,0,0, 3072,256,0, 2048,256,0});
    // t clamped low, then high
    add_row('{0,0,0, 256,0,0, 512,512,0, 1024,2048,0});
    add_row('{0,0,0, 256,0,0, -1024,-2048,0, -512,-512,0});
    // rounding of the points, odd differences
    add_row('{1,3,-5, 2,-7,4, -3,1,1, 6,-2,9});
    add_row('{0,0,0, 3,0,0, 1,1,0, 1,-1,0});
  endfunction

  function automatic int rnd_coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // random pair: mostly general, some degenerate or parallel
  function automatic pair_t rnd_pair();
    pair_t p;
    int    kind, span, k;
    kind = $urandom_range(9);
    span = ($urandom_range(3) == 0) ? 32767 : (1 << $urandom_range(12, 2));
    for (int i = 0; i < 12; i++) begin
      if (span == 32767) p.c[i] = coord_t'($urandom);
      else p.c[i] = coord_t'(rnd_coord(span));
    end
    case (kind)
      0: begin
        for (int i = 0; i < 3; i++) p.c[3 + i] = p.c[i];
      end
      1: begin
        for (int i = 0; i < 3; i++) p.c[9 + i] = p.c[6 + i];
      end
      2: begin
        for (int i = 0; i < 3; i++) begin
          p.c[3 + i] = p.c[i];
          p.c[9 + i] = p.c[6 + i];
        end
      end
      3: begin
        // parallel, second direction a multiple of the first
        k = $urandom_range(4) - 2;
        for (int i = 0; i < 3; i++) begin
          p.c[i]     = coord_t'(rnd_coord(2000));
          p.c[3 + i] = coord_t'(p.c[i] + rnd_coord(800));
          p.c[6 + i] = coord_t'(rnd_coord(2000));
          p.c[9 + i] = coord_t'(p.c[6 + i] + k * (p.c[3 + i] - p.c[i]));
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  // one item onto the input channel
  task automatic send_pair(pair_t p);
    if ($urandom_range(99) < idle_pct) begin
      in_item.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_item.valid        <= 1'b1;
    in_item.seg1_start_x <= p.c[0];
    in_item.seg1_start_y <= p.c[1];
    in_item.seg1_start_z <= p.c[2];
    in_item.seg1_end_x   <= p.c[3];
    in_item.seg1_end_y   <= p.c[4];
    in_item.seg1_end_z   <= p.c[5];
    in_item.seg2_start_x <= p.c[6];
    in_item.seg2_start_y <= p.c[7];
    in_item.seg2_start_z <= p.c[8];
    in_item.seg2_end_x   <= p.c[9];
    in_item.seg2_end_y   <= p.c[10];
    in_item.seg2_end_z   <= p.c[11];
    do @(posedge clk); while (!in_item.ready);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_item.ready <= ($urandom_range(99) >= stall_pct);
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_closest_points_between_segments: done, errors");
      $finish;
    end
  end

  // predict on input items, check result items
  always @(posedge clk) begin
    pair_t p;
    near_t x;
    if (rst_n) begin
      if (in_item.valid && in_item.ready && (n_sent >= rows.size() ||
          !rows[n_sent].typed)) begin
        p.c = '{in_item.seg1_start_x, in_item.seg1_start_y, in_item.seg1_start_z,
                in_item.seg1_end_x, in_item.seg1_end_y, in_item.seg1_end_z,
                in_item.seg2_start_x, in_item.seg2_start_y, in_item.seg2_start_z,
                in_item.seg2_end_x, in_item.seg2_end_y, in_item.seg2_end_z};
        near_q.push_back(closest(p));
      end else if (in_item.valid && in_item.ready) begin
        near_q.push_back(rows[n_sent].res);
      end
      if (in_item.valid && in_item.ready) n_sent <= n_sent + 1;
      if (out_item.valid && out_item.ready) begin
        n_got <= n_got + 1;
        if (near_q.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          x = near_q.pop_front();
          if (out_item.param_s !== x.s) begin
            $error("param_s: expected %0d, got %0d", x.s, out_item.param_s); errors++;
          end
          if (out_item.param_t !== x.t) begin
            $error("param_t: expected %0d, got %0d", x.t, out_item.param_t); errors++;
          end
          if (out_item.near1_x !== x.n1[0]) begin
            $error("near1_x: expected %0d, got %0d", x.n1[0], out_item.near1_x); errors++;
          end
          if (out_item.near1_y !== x.n1[1]) begin
            $error("near1_y: expected %0d, got %0d", x.n1[1], out_item.near1_y); errors++;
          end
          if (out_item.near1_z !== x.n1[2]) begin
            $error("near1_z: expected %0d, got %0d", x.n1[2], out_item.near1_z); errors++;
          end
          if (out_item.near2_x !== x.n2[0]) begin
            $error("near2_x: expected %0d, got %0d", x.n2[0], out_item.near2_x); errors++;
          end
          if (out_item.near2_y !== x.n2[1]) begin
            $error("near2_y: expected %0d, got %0d", x.n2[1], out_item.near2_y); errors++;
          end
          if (out_item.near2_z !== x.n2[2]) begin
            $error("near2_z: expected %0d, got %0d", x.n2[2], out_item.near2_z); errors++;
          end
          if (out_item.dist_squared !== x.dsq) begin
            $error("dist_squared: expected %0d, got %0d", x.dsq, out_item.dist_squared);
            errors++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 45, 0, 17};
    stall_tab = '{0, 0, 45, 17};
    errors    = 0;
    n_sent    = 0;
    n_got     = 0;
    cycles    = 0;
    idle_pct  = 0;
    stall_pct = 0;
    rst_n     = 1'b0;
    in_item.valid = 1'b0;
    {in_item.seg1_start_x, in_item.seg1_start_y, in_item.seg1_start_z} = '0;
    {in_item.seg1_end_x, in_item.seg1_end_y, in_item.seg1_end_z} = '0;
    {in_item.seg2_start_x, in_item.seg2_start_y, in_item.seg2_start_z} = '0;
    {in_item.seg2_end_x, in_item.seg2_end_y, in_item.seg2_end_z} = '0;
    out_item.ready = 1'b1;
    build_rows();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    foreach (rows[i]) send_pair(rows[i].pair);

    // random part in four phases of idling and stalls
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      repeat (210) send_pair(rnd_pair());
    end
    in_item.valid <= 1'b0;
    stall_pct = 0;

    while (near_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d segment pairs (%0d directed) over four idling phases,",
             n_sent, rows.size());
    $display("degenerate, parallel, clamped and full-range cases; %0d results checked",
             n_got);
    if (errors == 0) begin
      $display("tb_closest_points_between_segments: done, clean");
    end else begin
      $display("tb_closest_points_between_segments: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
